### hdl/urld_pkg.sv
`timescale 1ns / 1ps

package urld_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] NINE_CHAR  = 8'h39;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] CASE_GAP   = 8'h20;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    localparam int QUEUE_DEPTH_DEF = 4;

    // One decode command: either one beat (data, last) or, when split is set,
    // a literal '%' with last low followed by data with last high.
    typedef struct packed {
        logic       split;
        logic [7:0] data;
        logic       last;
    } cmd_t;

endpackage

### hdl/urld_if.sv
`timescale 1ns / 1ps

interface urld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface urld_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

### hdl/url_percent_decoder.sv
`timescale 1ns / 1ps
// The beat for a byte passes through the command queue and then the registered output
// stage before it is valid on the output; '%' and the first digit give no beat.
// Throughput: one input byte per cycle while the command queue has room; a string that
// ends one byte after '%' yields two output beats, emitted in turn by the output stage.
// The command queue between front and back (QUEUE_DEPTH entries) absorbs output stalls.
// Reset (rst_n low, asynchronous) clears the escape phase, the queue and the output beat.

module url_percent_decoder
#(
    parameter int QUEUE_DEPTH = urld_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    urld_in_if.sink    in_stream,
    urld_out_if.source out_stream
);
    import urld_pkg::*;

    logic push_valid;
    cmd_t push_cmd;
    logic push_ready;
    logic pop_valid;
    cmd_t pop_cmd;
    logic pop_ready;

    urld_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_stream),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    urld_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    urld_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready),
        .out_stream (out_stream)
    );

endmodule

### hdl/urld_front.sv
`timescale 1ns / 1ps

module urld_front
(
    input  logic          clk,
    input  logic          rst_n,
    urld_in_if.sink       in_stream,
    output logic          push_valid,
    output urld_pkg::cmd_t push_cmd,
    input  logic          push_ready
);
    import urld_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PCT  = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic       accept;
    logic       emit;
    logic [7:0] digit;
    logic [7:0] lowered;
    logic [7:0] plain;

    always_comb
    begin
        lowered = in_stream.in_byte;
        if (in_stream.in_byte inside {[UPPER_A:UPPER_Z]})
        begin
            lowered = in_stream.in_byte + CASE_GAP;
        end
        if (in_stream.in_byte inside {[ZERO_CHAR:NINE_CHAR]})
        begin
            digit = in_stream.in_byte - ZERO_CHAR;
        end
        else
        begin
            digit = lowered - LOWER_A + HEX_TEN;
        end
        plain = (in_stream.in_byte == PLUS_CHAR) ? SPACE_CHAR : in_stream.in_byte;
    end

    assign in_stream.ready = push_ready;
    assign accept          = in_stream.valid && in_stream.ready;
    assign push_valid      = accept && emit;

    always_comb
    begin
        phase_next     = phase_reg;
        held_next      = held_reg;
        emit           = 1'b1;
        push_cmd.split = 1'b0;
        push_cmd.data  = plain;
        push_cmd.last  = in_stream.in_last;
        case (phase_reg)
            PH_PCT:
            begin
                if (in_stream.in_last)
                begin
                    push_cmd.split = 1'b1;
                    phase_next     = PH_IDLE;
                end
                else
                begin
                    emit       = 1'b0;
                    held_next  = digit;
                    phase_next = PH_HI;
                end
            end
            PH_HI:
            begin
                push_cmd.data = {held_reg[3:0], 4'd0} | digit;
                phase_next    = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (in_stream.in_byte == PCT_CHAR && !in_stream.in_last)
                begin
                    emit       = 1'b0;
                    phase_next = PH_PCT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

### hdl/urld_queue.sv
`timescale 1ns / 1ps

module urld_queue
#(
    parameter int DEPTH = urld_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  urld_pkg::cmd_t push_cmd,
    output logic           push_ready,
    output logic           pop_valid,
    output urld_pkg::cmd_t pop_cmd,
    input  logic           pop_ready
);
    import urld_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

### hdl/urld_back.sv
`timescale 1ns / 1ps

module urld_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    input  urld_pkg::cmd_t pop_cmd,
    output logic           pop_ready,
    urld_out_if.source     out_stream
);
    import urld_pkg::*;

    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       pend_reg;
    logic [7:0] pend_data_reg;
    logic       slot_free;
    logic       do_pop;

    assign out_stream.valid    = out_valid_reg;
    assign out_stream.out_byte = out_data_reg;
    assign out_stream.out_last = out_last_reg;

    assign slot_free = !out_valid_reg || out_stream.ready;
    // hold the queue while the second beat of a split command is pending
    assign pop_ready = slot_free && !pend_reg;
    assign do_pop    = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            out_data_reg  <= pop_cmd.split ? PCT_CHAR : pop_cmd.data;
            out_last_reg  <= pop_cmd.split ? 1'b0 : pop_cmd.last;
            pend_data_reg <= pop_cmd.data;
        end
        else if (pend_reg && slot_free)
        begin
            out_data_reg <= pend_data_reg;
            out_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else if (do_pop)
        begin
            out_valid_reg <= 1'b1;
            pend_reg      <= pop_cmd.split;
        end
        else if (pend_reg && slot_free)
        begin
            out_valid_reg <= 1'b1;
            pend_reg      <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    a_pend_shows_pct: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (out_valid_reg && !out_last_reg && out_data_reg == PCT_CHAR))
        else $error("pending second beat without a literal percent beat in front");

    a_split_then_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && out_stream.ready) |=> (out_valid_reg && out_last_reg && !pend_reg))
        else $error("second beat of a split command not delivered with last");

    a_no_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !do_pop)
        else $error("queue popped while a second beat is pending");

endmodule
